// ----- rtl/core/cdf_flow_size_sampler_core_macros.svh -----
// Assertion macros for the flow size sampler core.
// Used by the port checker; no dependencies.
`ifndef CDF_FLOW_SIZE_SAMPLER_CORE_MACROS_SVH
`define CDF_FLOW_SIZE_SAMPLER_CORE_MACROS_SVH

// Assert a property outside reset
`define CFS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assert a property at every edge, reset included
`define CFS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/core/cfs_pkg.sv -----
// Shared constants, types and codes for the flow size sampler core.
// No dependencies; imported by every module of the block but cfs_ram.
package cfs_pkg;

    // Table geometry
    localparam int unsigned TABLE_DEPTH = 64;
    localparam int unsigned ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int unsigned CNT_W       = $clog2(TABLE_DEPTH + 1);

    // Field widths
    localparam int unsigned IDX_W  = 6;
    localparam int unsigned PROB_W = 17;
    localparam int unsigned SIZE_W = 32;
    localparam int unsigned LEN_W  = 7;
    localparam int unsigned PROD_W = PROB_W + SIZE_W;
    localparam int unsigned ENTRY_W = PROB_W + SIZE_W;

    // Stream widths
    localparam int unsigned S_TDATA_W = 72;
    localparam int unsigned M_TDATA_W = 32;

    // Configuration port
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_TABLE_LENGTH = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FALLBACK     = 1'd1;

    // Constants
    localparam logic [PROB_W-1:0] PROB_ONE       = 17'h10000;
    localparam logic [SIZE_W-1:0] FALLBACK_RESET = 32'd50;

    // Request kinds
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_DRAW  = 1'b1;

    // Divider request and response
    typedef struct packed {
        logic              start;
        logic [PROD_W-1:0] dividend;
        logic [PROB_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [SIZE_W-1:0] quotient;
    } t_div_rsp;

endpackage

// ----- rtl/core/cfs_ram.sv -----
// Simple dual-port synchronous RAM, one write and one registered read port.
// Generic; no package dependencies.
module cfs_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16,
    localparam int unsigned AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/cfs_div.sv -----
// Restoring divider, one quotient bit per cycle, for the interpolation step.
// Depends on cfs_pkg for widths and the request/response structs.
module cfs_div
    import cfs_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    localparam int unsigned STEP_W = $clog2(SIZE_W);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_cnt;
    logic [PROB_W-1:0] r_rem;
    logic [PROB_W-1:0] r_den;
    logic [SIZE_W-1:0] r_q;

    logic [PROB_W:0]   trial;
    logic              ge;
    logic [PROB_W:0]   diff;

    // Shift the next dividend bit into the partial remainder and compare
    always_comb begin
        trial = {r_rem, r_q[SIZE_W-1]};
        ge    = (trial >= {1'b0, r_den});
        diff  = trial - {1'b0, r_den};
    end

    // Control: start, step count, done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == STEP_W'(SIZE_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: high dividend bits seed the remainder, low bits become quotient
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= i_req.dividend[PROD_W-1:SIZE_W];
            r_q   <= i_req.dividend[SIZE_W-1:0];
            r_den <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= ge ? diff[PROB_W-1:0] : trial[PROB_W-1:0];
            r_q   <= {r_q[SIZE_W-2:0], ge};
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_q;

endmodule

// ----- rtl/core/cdf_flow_size_sampler_core.sv -----
// Flow size sampler: a table write gives no result. A draw reaches its result
// through a scan of at most L entries, L being the clamped table length
// (64 for a full table): one entry read per cycle from the table RAM,
// a 17x32 multiply and a serial divide; a full output register adds wait.
// Synchronous active-low reset clears control and config; table contents
// are undefined until written, with no clearing pass.
module cdf_flow_size_sampler_core
    import cfs_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration write port
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    // requests
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // [5:0] entry_index, [22:6] entry_prob, [54:23] entry_size,
    // [71:55] uniform_draw
    input  logic [S_TDATA_W-1:0]  s_axis_tdata,
    // [0] opcode
    input  logic [0:0]            s_axis_tuser,
    // results
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [31:0] flow_size
    output logic [M_TDATA_W-1:0]  m_axis_tdata,
    // [0] matched
    output logic [0:0]            m_axis_tuser
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_PREP,
        S_MUL,
        S_DIVGO,
        S_DIVWAIT,
        S_DONE
    } t_state;

    t_state r_state;

    // Configuration
    logic [LEN_W-1:0]  r_table_len;
    logic [SIZE_W-1:0] r_fallback;

    // Draw context
    logic [PROB_W-1:0] r_u;
    logic [CNT_W-1:0]  r_len;
    logic [CNT_W-1:0]  r_addr;
    logic              r_pend;
    logic              r_hit;
    logic [PROB_W-1:0] r_prev_prob;
    logic [SIZE_W-1:0] r_prev_size;
    logic [PROB_W-1:0] r_p1;
    logic [SIZE_W-1:0] r_s1;
    logic [PROB_W-1:0] r_num;
    logic [PROB_W-1:0] r_den;
    logic [SIZE_W-1:0] r_d;
    logic              r_up;
    logic [PROD_W-1:0] r_prod;
    logic [SIZE_W-1:0] r_q;

    // Output register
    logic              r_out_valid;
    logic [SIZE_W-1:0] r_out_size;
    logic              r_out_match;

    // Request fields
    logic              in_op;
    logic [IDX_W-1:0]  in_idx;
    logic [PROB_W-1:0] in_prob;
    logic [SIZE_W-1:0] in_size;
    logic [PROB_W-1:0] in_draw;
    logic              s_accept;

    // RAM and divider hookup
    logic               ram_we;
    logic               ram_re;
    logic [ENTRY_W-1:0] ram_rdata;
    logic [PROB_W-1:0]  rd_prob;
    logic [SIZE_W-1:0]  rd_size;
    t_div_req           div_req;
    t_div_rsp           div_rsp;

    // Next values
    logic [PROB_W-1:0] n_u;
    logic [CNT_W-1:0]  n_len;
    logic [SIZE_W-1:0] n_interp;
    logic [SIZE_W-1:0] n_result;
    logic              out_free;
    logic              out_load;

    // Unpack request
    assign in_op    = s_axis_tuser[0];
    assign in_idx   = s_axis_tdata[5:0];
    assign in_prob  = s_axis_tdata[22:6];
    assign in_size  = s_axis_tdata[54:23];
    assign in_draw  = s_axis_tdata[71:55];

    assign s_axis_tready = (r_state == S_IDLE);
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    // Clamp the draw to one and the length to the table depth
    assign n_u   = (in_draw > PROB_ONE) ? PROB_ONE : in_draw;
    assign n_len = (32'(r_table_len) > 32'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH)
                                                        : CNT_W'(r_table_len);

    // Table write on a write request, scan read while entries remain
    assign ram_we = s_accept && (in_op == OP_WRITE) && (32'(in_idx) < 32'(TABLE_DEPTH));
    assign ram_re = (r_state == S_SCAN) && (r_addr != r_len);

    cfs_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ADDR_W'(in_idx)),
        .i_wdata ({in_prob, in_size}),
        .i_re    (ram_re),
        .i_raddr (r_addr[ADDR_W-1:0]),
        .o_rdata (ram_rdata)
    );

    assign rd_prob = ram_rdata[ENTRY_W-1:SIZE_W];
    assign rd_size = ram_rdata[SIZE_W-1:0];

    // Round the quotient up when the size falls between entries
    assign div_req.start    = (r_state == S_DIVGO);
    assign div_req.dividend = r_up ? r_prod : r_prod + PROD_W'(r_den - 1'b1);
    assign div_req.divisor  = r_den;

    cfs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // Final size: fall back when nothing matched or the result is zero
    assign n_interp = r_up ? (r_prev_size + r_q) : (r_prev_size - r_q);
    assign n_result = (!r_hit || (n_interp == '0)) ? r_fallback : n_interp;
    assign out_free = !r_out_valid || m_axis_tready;
    assign out_load = (r_state == S_DONE) && out_free;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_len <= '0;
            r_fallback  <= FALLBACK_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_TABLE_LENGTH: r_table_len <= i_cfg_wdata[LEN_W-1:0];
                CFG_FALLBACK:     r_fallback  <= i_cfg_wdata[SIZE_W-1:0];
                default:          ;
            endcase
        end
    end

    // Sequencer: scan, interpolate, hand over to the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_pend      <= 1'b0;
            r_hit       <= 1'b0;
        end else begin
            // Load a finished result, else drop one the sink has taken
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (s_accept && (in_op == OP_DRAW)) begin
                        r_u         <= n_u;
                        r_len       <= n_len;
                        r_addr      <= '0;
                        r_pend      <= 1'b0;
                        r_hit       <= 1'b0;
                        r_prev_prob <= '0;
                        r_prev_size <= '0;
                        r_state     <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (ram_re) begin
                        r_addr <= r_addr + 1'b1;
                    end
                    r_pend <= ram_re;
                    if (r_pend) begin
                        if (r_u <= rd_prob) begin
                            r_p1    <= rd_prob;
                            r_s1    <= rd_size;
                            r_hit   <= 1'b1;
                            r_state <= S_PREP;
                        end else begin
                            r_prev_prob <= rd_prob;
                            r_prev_size <= rd_size;
                        end
                    end else if (r_addr == r_len) begin
                        // table exhausted without a match
                        r_state <= S_DONE;
                    end
                end
                S_PREP: begin
                    r_num <= r_u - r_prev_prob;
                    r_den <= r_p1 - r_prev_prob;
                    r_up  <= (r_s1 >= r_prev_size);
                    r_d   <= (r_s1 >= r_prev_size) ? (r_s1 - r_prev_size)
                                                   : (r_prev_size - r_s1);
                    if (r_p1 <= r_prev_prob) begin
                        // flat step: keep the previous size
                        r_q     <= '0;
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_prod  <= PROD_W'(r_num) * PROD_W'(r_d);
                    r_state <= S_DIVGO;
                end
                S_DIVGO: begin
                    r_state <= S_DIVWAIT;
                end
                S_DIVWAIT: begin
                    if (div_rsp.done) begin
                        r_q     <= div_rsp.quotient;
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_size  <= n_result;
                        r_out_match <= r_hit;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid   = r_out_valid;
    assign m_axis_tdata    = r_out_size;
    assign m_axis_tuser[0] = r_out_match;

endmodule

// ----- rtl/core/cfs_chk.sv -----
// Port-level checker for the flow size sampler core, bound to the top level.
// Depends on cfs_pkg and cdf_flow_size_sampler_core_macros.svh.
`include "cdf_flow_size_sampler_core_macros.svh"

module cfs_chk
    import cfs_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 s_axis_tvalid,
    input logic                 s_axis_tready,
    input logic [0:0]           s_axis_tuser,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [M_TDATA_W-1:0] m_axis_tdata,
    input logic [0:0]           m_axis_tuser
);

    logic draw_acc;
    logic write_acc;

    assign draw_acc  = s_axis_tvalid && s_axis_tready && (s_axis_tuser[0] == OP_DRAW);
    assign write_acc = s_axis_tvalid && s_axis_tready && (s_axis_tuser[0] == OP_WRITE);

    // A stalled result holds
    `CFS_ASSERT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")

    // A draw blocks further requests while it is worked on
    `CFS_ASSERT(a_draw_busy, i_clk, i_rst_n, draw_acc |=> !s_axis_tready, "request taken during a draw")

    // A table write leaves the block ready for the next request
    `CFS_ASSERT(a_write_ready, i_clk, i_rst_n, write_acc |=> s_axis_tready, "table write stalled input")

    // A new result only follows a draw in flight
    `CFS_ASSERT(a_result_src, i_clk, i_rst_n, $rose(m_axis_tvalid) |-> !$past(s_axis_tready), "result without a draw")

    // Reset empties the output register
    `CFS_ASSERT_ALWAYS(a_reset_out, i_clk, !i_rst_n |=> !m_axis_tvalid, "result valid after reset")

endmodule

bind cdf_flow_size_sampler_core cfs_chk u_cfs_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

// ----- dv/cdf_flow_size_sampler_core_test.sv -----
// Self-checking testbench for cdf_flow_size_sampler_core: table writes and
// draws go in over the request stream, sampled sizes are checked on the result stream.
// Depends on cfs_pkg and the core RTL only.
module cdf_flow_size_sampler_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import cfs_pkg::*;

    localparam int unsigned NUM_PHASES   = 24;
    localparam int unsigned MIX_ITEMS    = 32;
    localparam int unsigned DRAIN_CYCLES = 150;
    localparam int unsigned CYCLE_LIMIT  = 1_000_000;

    typedef struct packed {
        logic              op;
        logic [IDX_W-1:0]  idx;
        logic [PROB_W-1:0] prob;
        logic [SIZE_W-1:0] size;
        logic [PROB_W-1:0] draw;
    } t_sampler_req;

    typedef struct packed {
        logic [SIZE_W-1:0] flow_size;
        logic              matched;
    } t_flow_result;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // [5:0] entry_index, [22:6] entry_prob, [54:23] entry_size,
    // [71:55] uniform_draw
    logic [S_TDATA_W-1:0]  s_axis_tdata = '0;
    // [0] opcode
    logic [0:0]            s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // [31:0] flow_size
    logic [M_TDATA_W-1:0]  m_axis_tdata;
    // [0] matched
    logic [0:0]            m_axis_tuser;

    // Request stream feed and expected results
    t_sampler_req sampler_requests[$];
    t_sampler_req active_req;
    t_flow_result expected_sizes[$];

    // Shadow of the distribution table and the two registers
    logic [PROB_W-1:0] cdf_prob[TABLE_DEPTH];
    logic [SIZE_W-1:0] cdf_size[TABLE_DEPTH];
    logic [LEN_W-1:0]  cdf_len = '0;
    logic [SIZE_W-1:0] cdf_fallback = FALLBACK_RESET;

    // Probabilities as queued, used to aim draws at table boundaries
    logic [PROB_W-1:0] planned_prob[TABLE_DEPTH];

    int unsigned sender_idle_pct = 22;
    int unsigned recv_stall_pct  = 67;
    int unsigned mismatch_count  = 0;
    int unsigned cycle_count     = 0;

    cdf_flow_size_sampler_core u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Clock and reset
    initial begin
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Scan the shadow table for the first entry covering the draw and interpolate
    function automatic t_flow_result sample_flow_size(input logic [PROB_W-1:0] draw);
        t_flow_result res;
        logic [PROB_W-1:0] u, p0, p1;
        logic [SIZE_W-1:0] s0, s1, size;
        logic [63:0]       num, den, span, quo;
        int unsigned       n;
        bit                hit;
        u    = (draw > PROB_ONE) ? PROB_ONE : draw;
        n    = (cdf_len > TABLE_DEPTH) ? TABLE_DEPTH : cdf_len;
        hit  = 1'b0;
        size = '0;
        for (int i = 0; i < n && !hit; i++) begin
            if (u <= cdf_prob[i]) begin
                p0 = (i == 0) ? '0 : cdf_prob[i-1];
                s0 = (i == 0) ? '0 : cdf_size[i-1];
                p1 = cdf_prob[i];
                s1 = cdf_size[i];
                if (p1 <= p0) begin
                    size = s0;
                end else begin
                    num = 64'(u) - 64'(p0);
                    den = 64'(p1) - 64'(p0);
                    // truncate toward zero: floor going up, ceiling going down
                    if (s1 >= s0) begin
                        span = 64'(s1) - 64'(s0);
                        quo  = (num * span) / den;
                        size = s0 + quo[SIZE_W-1:0];
                    end else begin
                        span = 64'(s0) - 64'(s1);
                        quo  = (num * span + den - 1) / den;
                        size = s0 - quo[SIZE_W-1:0];
                    end
                end
                hit = 1'b1;
            end
        end
        if (!hit || size == '0) size = cdf_fallback;
        res.flow_size = size;
        res.matched   = hit;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%t ERROR %s: got %0h expected %0h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    task automatic queue_write(input logic [IDX_W-1:0] idx, input logic [PROB_W-1:0] prob,
                               input logic [SIZE_W-1:0] size);
        t_sampler_req req;
        req.op   = OP_WRITE;
        req.idx  = idx;
        req.prob = prob;
        req.size = size;
        req.draw = PROB_W'($urandom);
        planned_prob[idx] = prob;
        sampler_requests = {sampler_requests, req};
    endtask

    task automatic queue_draw(input logic [PROB_W-1:0] draw);
        t_sampler_req req;
        req.op   = OP_DRAW;
        req.idx  = IDX_W'($urandom);
        req.prob = PROB_W'($urandom);
        req.size = $urandom;
        req.draw = draw;
        sampler_requests = {sampler_requests, req};
    endtask

    // Write a well-formed CDF into slots 0..n-1: nondecreasing probability and size
    task automatic build_cdf(input int unsigned n);
        logic [63:0] p_acc, s_acc, s_step_max;
        p_acc = '0;
        s_acc = ($urandom_range(3) == 0) ? 64'd0 : 64'($urandom_range(1, 1000));
        case ($urandom_range(2))
            0: s_step_max = 64'd100;
            1: s_step_max = 64'd1_000_000;
            default: s_step_max = 64'hFFFF_FFFF / n;
        endcase
        for (int i = 0; i < n; i++) begin
            p_acc += 64'($urandom_range(0, 2 * 65536 / n));
            if (p_acc > 64'd65536 || (i == n - 1 && $urandom_range(1) == 1)) begin
                p_acc = 64'd65536;
            end
            s_acc += 64'($urandom) % (s_step_max + 1);
            if (s_acc > 64'hFFFF_FFFF) s_acc = 64'hFFFF_FFFF;
            queue_write(IDX_W'(i), p_acc[PROB_W-1:0], s_acc[SIZE_W-1:0]);
        end
    endtask

    // Hold until every request is taken and every result is back, then let the core settle
    task automatic wait_idle();
        do @(posedge i_clk);
        while (sampler_requests.size() != 0 || s_axis_tvalid || expected_sizes.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        if (idx == CFG_TABLE_LENGTH) cdf_len = value[LEN_W-1:0];
        else cdf_fallback = value;
    endtask

    // Request driver: present the next request once the previous one is taken
    always @(posedge i_clk) begin : driver
        t_sampler_req req;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (s_axis_tvalid) begin
                if (active_req.op == OP_WRITE) begin
                    cdf_prob[active_req.idx] = active_req.prob;
                    cdf_size[active_req.idx] = active_req.size;
                end else begin
                    expected_sizes = {expected_sizes, sample_flow_size(active_req.draw)};
                end
            end
            if (sampler_requests.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                req           = sampler_requests.pop_front();
                active_req    = req;
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {req.draw, req.size, req.prob, req.idx};
                s_axis_tuser  <= req.op;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Result monitor: compare each result with the oldest expectation
    always @(posedge i_clk) begin : monitor
        t_flow_result want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_sizes.size() == 0) begin
                    report_mismatch("unexpected result", m_axis_tdata[31:0], '0);
                end else begin
                    want = expected_sizes.pop_front();
                    if (m_axis_tdata[SIZE_W-1:0] !== want.flow_size) begin
                        report_mismatch("flow_size", m_axis_tdata[SIZE_W-1:0], want.flow_size);
                    end
                    if (m_axis_tuser[0] !== want.matched) begin
                        report_mismatch("matched", 32'(m_axis_tuser[0]), 32'(want.matched));
                    end
                end
            end
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Stimulus sequence
    initial begin : stimulus
        logic [LEN_W-1:0]  len;
        logic [SIZE_W-1:0] fallback;
        logic [PROB_W-1:0] d;
        int unsigned       sel, slot, n;
        foreach (planned_prob[i]) planned_prob[i] = '0;
        @(posedge i_rst_n);

        // Empty table after reset: every draw falls back
        queue_draw(17'd0);
        queue_draw(PROB_ONE);

        // Zero first entry, flat segment, falling size, full size, probability above one
        queue_write(6'd0, 17'd0, 32'd0);
        queue_write(6'd1, 17'd16384, 32'd1000);
        queue_write(6'd2, 17'd32768, 32'd1000);
        queue_write(6'd3, 17'd49152, 32'd500);
        queue_write(6'd4, PROB_ONE, 32'hFFFF_FFFF);
        queue_write(6'd5, 17'h1FFFF, 32'd7);
        wait_idle();
        write_register(CFG_TABLE_LENGTH, 32'd5);
        write_register(CFG_FALLBACK, 32'hFFFF_FFFF);
        queue_draw(17'd0);
        queue_draw(17'd1);
        queue_draw(17'd16384);
        queue_draw(17'd20000);
        queue_draw(17'd40000);
        queue_draw(17'd65535);
        queue_draw(PROB_ONE);
        queue_draw(17'h1FFFF);
        queue_draw(17'd70000);
        wait_idle();

        // Short table: a draw past the last entry is unmatched
        write_register(CFG_TABLE_LENGTH, 32'd3);
        write_register(CFG_FALLBACK, 32'd0);
        queue_draw(17'd50000);
        queue_draw(17'd32768);

        // Fill every slot so any length reads written entries only
        build_cdf(TABLE_DEPTH);
        wait_idle();

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            if (phase < NUM_PHASES / 3) begin
                sender_idle_pct = 22;
                recv_stall_pct  = 67;
            end else if (phase < 2 * NUM_PHASES / 3) begin
                sender_idle_pct = 67;
                recv_stall_pct  = 22;
            end else begin
                sender_idle_pct = 0;
                recv_stall_pct  = 0;
            end

            case (phase)
                0: len = 7'd127;
                1: len = 7'd0;
                2: len = 7'd64;
                3: len = 7'd1;
                4: len = 7'd65;
                default: len = ($urandom_range(3) == 0) ? LEN_W'($urandom_range(65, 127))
                                                        : LEN_W'($urandom_range(0, 64));
            endcase
            case (phase)
                0: fallback = 32'd0;
                1: fallback = 32'hFFFF_FFFF;
                2: fallback = FALLBACK_RESET;
                default: fallback = ($urandom_range(2) == 0) ? $urandom_range(0, 1000) : $urandom;
            endcase
            write_register(CFG_TABLE_LENGTH, 32'(len));
            write_register(CFG_FALLBACK, fallback);

            // Mostly start from a fresh CDF, often exactly as long as the table
            if ($urandom_range(4) != 0) begin
                if (len >= 1 && len <= 64 && $urandom_range(1) == 1) n = len;
                else n = $urandom_range(1, TABLE_DEPTH);
                build_cdf(n);
            end

            // Draws aimed at boundaries, mixed with some rewrites and noise
            repeat (MIX_ITEMS) begin
                sel  = $urandom_range(99);
                slot = $urandom_range(TABLE_DEPTH - 1);
                if (sel < 6) begin
                    queue_write(IDX_W'(slot), planned_prob[slot] + PROB_W'($urandom_range(0, 64))
                                - PROB_W'(32), $urandom);
                end else if (sel < 12) begin
                    queue_write(IDX_W'(slot), PROB_W'($urandom), $urandom);
                end else begin
                    sel = $urandom_range(99);
                    if (sel < 40) d = PROB_W'($urandom_range(0, 65536));
                    else if (sel < 55) d = planned_prob[slot];
                    else if (sel < 65) d = planned_prob[slot] + 1'b1;
                    else if (sel < 75) d = PROB_W'($urandom);
                    else if (sel < 80) d = '0;
                    else if (sel < 85) d = PROB_ONE;
                    else d = PROB_W'($urandom_range(0, 255));
                    queue_draw(d);
                end
            end
            wait_idle();
        end

        if (mismatch_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ----- cdf_flow_size_sampler_core.f -----
+incdir+rtl/core
rtl/core/cfs_pkg.sv
rtl/core/cfs_ram.sv
rtl/core/cfs_div.sv
rtl/core/cdf_flow_size_sampler_core.sv
rtl/core/cfs_chk.sv
dv/cdf_flow_size_sampler_core_test.sv
